/* design/sepc_pkg.sv */
`default_nettype none

package sepc_pkg;

	// Store sizes in 16-bit words; both are powers of two
	localparam int CART_WORDS     = 1024;
	localparam int INTERNAL_WORDS = 256;
	localparam int CART_AW        = $clog2(CART_WORDS);
	localparam int INT_AW         = $clog2(INTERNAL_WORDS);
	localparam int CLR_WORDS      = (CART_WORDS > INTERNAL_WORDS) ? CART_WORDS : INTERNAL_WORDS;
	localparam int CLR_AW         = $clog2(CLR_WORDS);

	localparam int NUM_SLOTS = 10;
	localparam int WORD_W    = 16;
	localparam int ADDR_W    = 10;
	localparam int CMD_W     = 4;
	localparam int KIND_W    = 2;
	localparam int PADDR_W   = 2;
	localparam int PDATA_W   = 32;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		SLOT_BA = 4'd0,
		SLOT_BB = 4'd1,
		SLOT_BC = 4'd2,
		SLOT_BD = 4'd3,
		SLOT_BE = 4'd4,
		SLOT_C4 = 4'd5,
		SLOT_C5 = 4'd6,
		SLOT_C6 = 4'd7,
		SLOT_C7 = 4'd8,
		SLOT_C8 = 4'd9
	} slot_t;

	// Cartridge store kinds; the fourth code behaves as no store
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_1K   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_16K  = 2'd2;

	localparam logic [PADDR_W-1:0] REG_EEPROM_KIND = 2'd0;

	localparam logic [7:0] PORT_BA = 8'hBA;
	localparam logic [7:0] PORT_BB = 8'hBB;
	localparam logic [7:0] PORT_BC = 8'hBC;
	localparam logic [7:0] PORT_BD = 8'hBD;
	localparam logic [7:0] PORT_BE = 8'hBE;
	localparam logic [7:0] PORT_C4 = 8'hC4;
	localparam logic [7:0] PORT_C5 = 8'hC5;
	localparam logic [7:0] PORT_C6 = 8'hC6;
	localparam logic [7:0] PORT_C7 = 8'hC7;
	localparam logic [7:0] PORT_C8 = 8'hC8;

	localparam logic [7:0] BE_WRITE        = 8'h20;
	localparam logic [7:0] BE_READ         = 8'h10;
	localparam logic [7:0] CTL_PROTECT     = 8'h40;
	localparam logic [7:0] CTL_WRITE       = 8'h20;
	localparam logic [7:0] CTL_READ        = 8'h10;
	localparam logic [7:0] DONE_WRITE      = 8'h02;
	localparam logic [7:0] DONE_READ       = 8'h01;
	localparam logic [7:0] KIND1_ADDR_MASK = 8'h3F;

	localparam logic [CMD_W-1:0] CMD_SPECIAL   = 4'hC;
	localparam logic [CMD_W-1:0] CMD_PROTECT   = 4'h0;
	localparam logic [CMD_W-1:0] CMD_UNPROTECT = 4'h3;
	localparam logic [CMD_W-1:0] CMD_WRITE     = 4'h4;

	typedef struct packed {
		logic  hit;
		slot_t slot;
	} slot_dec_t;

	typedef struct packed {
		op_t        op;
		logic       hit;
		slot_t      slot;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] port_bytes;
		logic [ADDR_W-1:0]         addr;
		logic [CMD_W-1:0]          cmd;
		logic                      we;
		logic                      int_we;
		logic [WORD_W-1:0]         int_wdata;
		logic                      cart_we;
		logic [WORD_W-1:0]         cart_wdata;
		logic [7:0]                result;
	} upd_t;

	function automatic slot_dec_t decode_port(input logic [7:0] port);
		slot_dec_t d;
		d.hit = 1'b1;
		d.slot = SLOT_BA;
		unique case (port)
			PORT_BA: d.slot = SLOT_BA;
			PORT_BB: d.slot = SLOT_BB;
			PORT_BC: d.slot = SLOT_BC;
			PORT_BD: d.slot = SLOT_BD;
			PORT_BE: d.slot = SLOT_BE;
			PORT_C4: d.slot = SLOT_C4;
			PORT_C5: d.slot = SLOT_C5;
			PORT_C6: d.slot = SLOT_C6;
			PORT_C7: d.slot = SLOT_C7;
			PORT_C8: d.slot = SLOT_C8;
			default: d.hit = 1'b0;
		endcase
		return d;
	endfunction

	// Keep only the special bits when any of them is set
	function automatic logic [CMD_W-1:0] reduce_command(input logic [CMD_W-1:0] c);
		return ((c & CMD_SPECIAL) != '0) ? (c & CMD_SPECIAL) : c;
	endfunction

endpackage

`default_nettype wire

/* design/sepc_ram.sv */
`default_nettype none

module sepc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/sepc_exec.sv */
`default_nettype none

module sepc_exec import sepc_pkg::*; (
	input  wire item_t                     item,
	input  wire logic [KIND_W-1:0]         kind,
	input  wire logic [NUM_SLOTS-1:0][7:0] port_bytes,
	input  wire logic [ADDR_W-1:0]         addr,
	input  wire logic [CMD_W-1:0]          cmd,
	input  wire logic                      we,
	input  wire logic [WORD_W-1:0]         int_rdata,
	input  wire logic [WORD_W-1:0]         cart_rdata,
	output upd_t                           upd
);

	logic [7:0]        data;
	logic              cart;
	logic [WORD_W-1:0] cart_word;

	assign cart = (kind == KIND_1K) || (kind == KIND_16K);

	always_comb begin
		data = item.data;
		cart_word = cart_rdata;
		upd.port_bytes = port_bytes;
		upd.addr = addr;
		upd.cmd = cmd;
		upd.we = we;
		upd.int_we = 1'b0;
		upd.int_wdata = {port_bytes[SLOT_BB], port_bytes[SLOT_BA]};
		upd.cart_we = 1'b0;
		upd.cart_wdata = {port_bytes[SLOT_C4], port_bytes[SLOT_C5]};
		upd.result = '0;
		if (item.hit) begin
			if (item.op == OP_WRITE) begin
				case (item.slot)
					SLOT_BE: begin
						if ((data & BE_WRITE) != '0) begin
							upd.int_we = 1'b1;
							data = data | DONE_WRITE;
						end else if ((data & BE_READ) != '0) begin
							upd.port_bytes[SLOT_BA] = int_rdata[7:0];
							upd.port_bytes[SLOT_BB] = int_rdata[15:8];
							data = data | DONE_READ;
						end
					end
					SLOT_C6: begin
						if (kind == KIND_1K) begin
							upd.addr = ADDR_W'(data & KIND1_ADDR_MASK);
							upd.cmd = reduce_command(data[7:4]);
						end else if (kind == KIND_16K) begin
							upd.addr = {addr[9:8], data};
						end
					end
					SLOT_C7: begin
						if (kind == KIND_16K) begin
							upd.addr = {data[1:0], addr[7:0]};
							upd.cmd = reduce_command(data[3:0]);
						end
					end
					SLOT_C8: begin
						if (cart) begin
							if ((data & CTL_PROTECT) != '0) begin
								if (cmd == CMD_PROTECT) begin
									upd.we = 1'b0;
								end else if (cmd == CMD_UNPROTECT) begin
									upd.we = 1'b1;
								end
							end
							if ((data & CTL_WRITE) != '0 && upd.we && cmd == CMD_WRITE) begin
								upd.cart_we = 1'b1;
								cart_word = upd.cart_wdata;
								data = data | DONE_WRITE;
							end
							// a read in the same request sees the word just written
							if ((data & CTL_READ) != '0) begin
								upd.port_bytes[SLOT_C4] = cart_word[15:8];
								upd.port_bytes[SLOT_C5] = cart_word[7:0];
								data = data | DONE_READ;
							end
						end
					end
					default: begin
					end
				endcase
				upd.port_bytes[item.slot] = data;
			end
			upd.result = upd.port_bytes[item.slot];
		end
	end

endmodule

`default_nettype wire

/* design/serial_eeprom_port_controller.sv */
// EEPROM port block: every request is one byte read or write to an I/O port and yields one
// result byte. After reset the block first fills both word stores with all ones, one word a
// cycle, holding in_stall high; register writes are taken meanwhile. A request then runs as
// follows: in the accept cycle the word stores are read at the current addresses, in the
// next the port bytes, address, command and store word are updated and the result is loaded
// into the output register. One request is in flight at a time, so no new request is taken
// until the last one has updated, nor while a stalled result is held; the read-modify-write
// of the word stores, whose two ports share one address, sets that limit.
`default_nettype none

module serial_eeprom_port_controller import sepc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [7:0]         port,
	input  wire logic [7:0]         write_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [7:0]         read_byte,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic [KIND_W-1:0]         kind_q;
	logic [NUM_SLOTS-1:0][7:0] port_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [CMD_W-1:0]          cmd_q;
	logic                      we_q;
	item_t                     item_s1;
	logic                      valid_s1;
	logic                      out_valid_q;
	logic [7:0]                read_byte_q;
	logic                      clearing_q;
	logic [CLR_AW-1:0]         clr_q;

	logic                      accept;
	slot_dec_t                 dec;
	upd_t                      upd;
	logic                      cart_we;
	logic [CART_AW-1:0]        cart_addr;
	logic [WORD_W-1:0]         cart_wdata;
	logic [WORD_W-1:0]         cart_rdata;
	logic                      int_we;
	logic [INT_AW-1:0]         int_addr;
	logic [WORD_W-1:0]         int_wdata;
	logic [WORD_W-1:0]         int_rdata;

	assign pready = 1'b1;
	assign prdata = PDATA_W'(kind_q);

	assign in_stall = clearing_q || valid_s1 || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign dec = decode_port(port);
	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;

	// Store addresses hold still from accept to update, so one address serves both ports
	assign cart_addr = clearing_q ? clr_q[CART_AW-1:0] : addr_q[CART_AW-1:0];
	assign int_addr = clearing_q ? clr_q[INT_AW-1:0] : INT_AW'(port_q[SLOT_BC]);
	assign cart_we = clearing_q ? ({1'b0, clr_q} < (CLR_AW+1)'(CART_WORDS))
	                            : (valid_s1 && upd.cart_we);
	assign int_we = clearing_q ? ({1'b0, clr_q} < (CLR_AW+1)'(INTERNAL_WORDS))
	                           : (valid_s1 && upd.int_we);
	assign cart_wdata = clearing_q ? '1 : upd.cart_wdata;
	assign int_wdata = clearing_q ? '1 : upd.int_wdata;

	sepc_ram #(.WIDTH(WORD_W), .DEPTH(CART_WORDS)) u_cart_ram (
		.clk   (clk),
		.we    (cart_we),
		.waddr (cart_addr),
		.wdata (cart_wdata),
		.raddr (cart_addr),
		.rdata (cart_rdata)
	);

	sepc_ram #(.WIDTH(WORD_W), .DEPTH(INTERNAL_WORDS)) u_int_ram (
		.clk   (clk),
		.we    (int_we),
		.waddr (int_addr),
		.wdata (int_wdata),
		.raddr (int_addr),
		.rdata (int_rdata)
	);

	sepc_exec u_exec (
		.item       (item_s1),
		.kind       (kind_q),
		.port_bytes (port_q),
		.addr       (addr_q),
		.cmd        (cmd_q),
		.we         (we_q),
		.int_rdata  (int_rdata),
		.cart_rdata (cart_rdata),
		.upd        (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
		end else if (clearing_q) begin
			if (clr_q == CLR_AW'(CLR_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
		end else if (psel && penable && pwrite && pready && paddr == REG_EEPROM_KIND) begin
			kind_q <= pwdata[KIND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			port_q <= '0;
			addr_q <= '0;
			cmd_q <= '0;
			we_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				port_q <= upd.port_bytes;
				addr_q <= upd.addr;
				cmd_q <= upd.cmd;
				we_q <= upd.we;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op <= op_t'(opcode);
			item_s1.hit <= dec.hit;
			item_s1.slot <= dec.slot;
			item_s1.data <= write_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_byte_q <= upd.result;
		end
	end

endmodule

`default_nettype wire

/* design/sepc_checker.sv */
`default_nettype none

module sepc_checker import sepc_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       opcode,
	input wire logic [7:0] port,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] read_byte
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_byte))
		else $error("stalled result changed");

	// one request in flight: the cycle after an accept is stalled
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another is in flight");

	// an accepted request's result is offered on out_valid after valid_s1
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("result missing after request");

	// reads of undecoded ports below the internal block return zero
	a_undecoded: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OP_READ && port < PORT_BA |=> ##1 read_byte == 8'h00)
		else $error("undecoded port read gave non-zero data");

endmodule

bind serial_eeprom_port_controller sepc_checker u_sepc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.opcode    (opcode),
	.port      (port),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_byte (read_byte)
);

`default_nettype wire

/* tb/tb_serial_eeprom_port_controller.sv */
`timescale 1ns / 1ps

module tb_serial_eeprom_port_controller;
	import sepc_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 155;
	localparam logic [KIND_W-1:0] KIND_PLAN [PHASES] =
		'{KIND_1K, KIND_16K, KIND_NONE, KIND_1K, KIND_16K, KIND_SPARE, KIND_1K, KIND_16K};
	localparam int SEND_IDLE [4] = '{0, 71, 0, 27};
	localparam int RECV_STALL [4] = '{0, 0, 71, 27};
	localparam logic [7:0] DECODED_PORTS [NUM_SLOTS] = '{PORT_BA, PORT_BB, PORT_BC, PORT_BD,
		PORT_BE, PORT_C4, PORT_C5, PORT_C6, PORT_C7, PORT_C8};

	// Mirror of the port bytes and word stores; holds the read bytes still owed by the block
	class eeprom_port_mirror;
		logic [KIND_W-1:0] kind;
		logic [7:0]        port_latch [NUM_SLOTS];
		logic [ADDR_W-1:0] word_addr;
		logic [CMD_W-1:0]  cmd;
		bit                write_en;
		logic [WORD_W-1:0] cart_words [CART_WORDS];
		logic [WORD_W-1:0] int_words [INTERNAL_WORDS];
		logic [7:0]        pending_bytes [$];
		int                faults;

		function new();
			kind = KIND_NONE;
			foreach (port_latch[i]) port_latch[i] = 8'h00;
			word_addr = '0;
			cmd = '0;
			write_en = 1'b0;
			foreach (cart_words[i]) cart_words[i] = '1;
			foreach (int_words[i]) int_words[i] = '1;
			faults = 0;
		endfunction

		function int slot_of(logic [7:0] p);
			if (p >= PORT_BA && p <= PORT_BE)
				return int'(p - PORT_BA);
			if (p >= PORT_C4 && p <= PORT_C8)
				return int'(p - PORT_C4) + int'(SLOT_C4);
			return -1;
		endfunction

		// A command with any special bit set keeps only those bits
		function logic [CMD_W-1:0] narrow_cmd(logic [CMD_W-1:0] c);
			if ((c & CMD_SPECIAL) != '0)
				return c & CMD_SPECIAL;
			return c;
		endfunction

		function void take_request(op_t op, logic [7:0] p, logic [7:0] d);
			int s;
			int ix;
			logic [7:0] v;
			bit cart;
			s = slot_of(p);
			v = 8'h00;
			cart = (kind == KIND_1K) || (kind == KIND_16K);
			if (s >= 0 && op == OP_READ) begin
				v = port_latch[s];
			end else if (s >= 0) begin
				v = d;
				case (s)
					SLOT_BE: begin
						ix = int'({port_latch[SLOT_BD], port_latch[SLOT_BC]} & 16'h00FF)
							% INTERNAL_WORDS;
						if ((v & BE_WRITE) != 0) begin
							int_words[ix] = {port_latch[SLOT_BB], port_latch[SLOT_BA]};
							v |= DONE_WRITE;
						end else if ((v & BE_READ) != 0) begin
							port_latch[SLOT_BA] = int_words[ix][7:0];
							port_latch[SLOT_BB] = int_words[ix][15:8];
							v |= DONE_READ;
						end
					end
					SLOT_C6: begin
						if (kind == KIND_1K) begin
							word_addr = ADDR_W'(v & KIND1_ADDR_MASK);
							cmd = narrow_cmd(v[7:4]);
						end else if (kind == KIND_16K) begin
							word_addr = {word_addr[9:8], v};
						end
					end
					SLOT_C7: begin
						if (kind == KIND_16K) begin
							word_addr = {v[1:0], word_addr[7:0]};
							cmd = narrow_cmd(v[3:0]);
						end
					end
					SLOT_C8: begin
						if (cart) begin
							ix = int'(word_addr) % CART_WORDS;
							if ((v & CTL_PROTECT) != 0) begin
								if (cmd == CMD_PROTECT)
									write_en = 1'b0;
								else if (cmd == CMD_UNPROTECT)
									write_en = 1'b1;
							end
							if ((v & CTL_WRITE) != 0 && write_en && cmd == CMD_WRITE) begin
								cart_words[ix] = {port_latch[SLOT_C4], port_latch[SLOT_C5]};
								v |= DONE_WRITE;
							end
							if ((v & CTL_READ) != 0) begin
								port_latch[SLOT_C4] = cart_words[ix][15:8];
								port_latch[SLOT_C5] = cart_words[ix][7:0];
								v |= DONE_READ;
							end
						end
					end
					default: ;
				endcase
				port_latch[s] = v;
			end
			pending_bytes.push_back(v);
		endfunction

		function void check_read_byte(logic [7:0] got);
			logic [7:0] want;
			if (pending_bytes.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("read_byte %02h arrived with no request outstanding", got);
				return;
			end
			want = pending_bytes.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display("read_byte mismatch: expected %02h, got %02h", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic [7:0] port = 8'h00;
	logic [7:0] write_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_byte;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	eeprom_port_mirror mirror;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_left = 0;
	int decoded_sent = 0;

	serial_eeprom_port_controller u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.port       (port),
		.write_byte (write_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_byte  (read_byte),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(255));
	endfunction

	// Favour a handful of low addresses so that fetches often hit stored words
	function automatic logic [7:0] pick_addr_lo();
		return ($urandom_range(1) != 0) ? 8'($urandom_range(7)) : rnd8();
	endfunction

	task automatic send_request(input op_t op, input logic [7:0] p, input logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		port <= p;
		write_byte <= d;
		do @(posedge clk); while (in_stall);
		mirror.take_request(op, p, d);
		if (mirror.slot_of(p) >= 0)
			decoded_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (mirror.pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_kind(input logic [KIND_W-1:0] k);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_EEPROM_KIND;
		pwdata <= PDATA_W'(k);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mirror.kind = k;
	endtask

	// Load address and command through whichever ports the current layout decodes
	task automatic set_cart_cmd(input logic [CMD_W-1:0] c);
		if (mirror.kind == KIND_1K) begin
			send_request(OP_WRITE, PORT_C6, {c, 4'($urandom_range(15))});
		end else begin
			send_request(OP_WRITE, PORT_C6, pick_addr_lo());
			send_request(OP_WRITE, PORT_C7, {4'($urandom_range(15)), c});
		end
	endtask

	task automatic send_random_burst();
		case ($urandom_range(9))
			0: begin
				send_request(OP_WRITE, PORT_BA, rnd8());
				send_request(OP_WRITE, PORT_BB, rnd8());
				send_request(OP_WRITE, PORT_BC, pick_addr_lo());
				send_request(OP_WRITE, PORT_BD, rnd8());
				send_request(OP_WRITE, PORT_BE, rnd8() | BE_WRITE);
			end
			1: begin
				send_request(OP_WRITE, PORT_BC, pick_addr_lo());
				send_request(OP_WRITE, PORT_BD, rnd8());
				send_request(OP_WRITE, PORT_BE, (rnd8() & ~BE_WRITE) | BE_READ);
				send_request(OP_READ, PORT_BA, rnd8());
				send_request(OP_READ, PORT_BB, rnd8());
				send_request(OP_READ, PORT_BE, rnd8());
			end
			2: begin
				set_cart_cmd(CMD_UNPROTECT);
				send_request(OP_WRITE, PORT_C8, (rnd8() & 8'h8F) | CTL_PROTECT);
			end
			3, 4: begin
				send_request(OP_WRITE, PORT_C5, rnd8());
				send_request(OP_WRITE, PORT_C4, rnd8());
				set_cart_cmd(CMD_WRITE | CMD_W'($urandom_range(3)));
				send_request(OP_WRITE, PORT_C8, rnd8() | CTL_WRITE);
			end
			5, 6: begin
				set_cart_cmd(CMD_W'($urandom_range(15)));
				send_request(OP_WRITE, PORT_C8, rnd8() | CTL_READ);
				send_request(OP_READ, PORT_C5, rnd8());
				send_request(OP_READ, PORT_C4, rnd8());
			end
			7: begin
				set_cart_cmd(CMD_PROTECT);
				send_request(OP_WRITE, PORT_C8, rnd8() | CTL_PROTECT);
			end
			8: begin
				repeat (3)
					send_request(op_t'($urandom_range(1)),
						DECODED_PORTS[$urandom_range(NUM_SLOTS - 1)], rnd8());
			end
			default: begin
				repeat (2)
					send_request(op_t'($urandom_range(1)), rnd8(), rnd8());
			end
		endcase
	endtask

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: check each delivered byte, then pick next cycle's stall
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				mirror.check_read_byte(read_byte);
			if (hold_off_left > 0) begin
				out_stall <= 1'b1;
				hold_off_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		mirror = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_kind(KIND_16K);

		send_request(OP_READ, PORT_BA, 8'h00);
		send_request(OP_READ, 8'h00, 8'h00);
		send_request(OP_WRITE, 8'hFF, 8'hFF);
		send_request(OP_WRITE, PORT_BC, 8'hFF);
		send_request(OP_WRITE, PORT_BD, 8'hFF);
		send_request(OP_WRITE, PORT_BE, BE_READ);
		send_request(OP_READ, PORT_BA, 8'h00);
		send_request(OP_WRITE, PORT_BA, 8'h34);
		send_request(OP_WRITE, PORT_BB, 8'h12);
		send_request(OP_WRITE, PORT_BE, BE_WRITE | BE_READ);
		send_request(OP_WRITE, PORT_BA, 8'h00);
		send_request(OP_WRITE, PORT_BE, BE_READ);
		send_request(OP_READ, PORT_BA, 8'h00);
		send_request(OP_WRITE, PORT_BE, 8'h00);
		send_request(OP_WRITE, PORT_C6, 8'hFF);
		send_request(OP_WRITE, PORT_C7, 8'h03);
		send_request(OP_WRITE, PORT_C8, CTL_PROTECT);
		send_request(OP_WRITE, PORT_C5, 8'hCD);
		send_request(OP_WRITE, PORT_C4, 8'hAB);
		send_request(OP_WRITE, PORT_C7, 8'h07);
		send_request(OP_WRITE, PORT_C8, 8'hF0);
		send_request(OP_READ, PORT_C4, 8'h00);
		send_request(OP_WRITE, PORT_C7, 8'h00);
		send_request(OP_WRITE, PORT_C8, CTL_PROTECT);
		send_request(OP_WRITE, PORT_C8, CTL_WRITE);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			repeat (4) @(posedge clk);
			write_kind(KIND_PLAN[p]);
			send_idle_pct = SEND_IDLE[p % 4];
			recv_stall_pct = RECV_STALL[p % 4];
			// hold the output off while requests keep coming, so the input backs up
			if (p == 4 || p == 6)
				hold_off_left = 150;
			decoded_sent = 0;
			while (decoded_sent < PHASE_REQUESTS)
				send_random_burst();
		end

		recv_stall_pct = 0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (mirror.faults == 0 && mirror.pending_bytes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
